### rtl/uwm_pkg.sv
// shared types and constants for the utf-8 display width meter
// no dependencies; imported by every module of the block
package uwm_pkg;

    localparam int CP_BITS    = 21;
    localparam int QDEPTH     = 4;
    localparam logic [15:0] RUN_MAX = 16'hffff;

    localparam logic [1:0] CONT_TAG = 2'b10;

    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    localparam logic [1:0] WIDTH_ZERO   = 2'd0;
    localparam logic [1:0] WIDTH_SINGLE = 2'd1;
    localparam logic [1:0] WIDTH_DOUBLE = 2'd2;

    typedef struct packed {
        logic [CP_BITS-1:0] code_point;
        logic [2:0]         unit_bytes;
        logic               final_unit;
    } t_unit;

endpackage

### rtl/uwm_front.sv
// front end: accepts text bytes, gathers utf-8 units and replays broken sequences
// depends on uwm_pkg; pushes one unit per cycle toward uwm_queue while the queue has room
module uwm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_in_byte,
    input  logic           i_in_last,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output uwm_pkg::t_unit o_push_unit
);
    import uwm_pkg::*;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = LEN_ONE;
            if (b[7:5] == 3'b110) len = LEN_TWO;
            else if (b[7:4] == 4'b1110) len = LEN_THREE;
            else if (b[7:3] == 5'b11110) len = LEN_FOUR;
            lead_length = len;
        end
    endfunction

    logic [7:0] r_held [3];
    logic [1:0] r_hc, n_hc;
    logic [2:0] r_exp, n_exp;
    logic [7:0] r_rep [3];
    logic [1:0] r_rep_cnt;
    logic       r_rep_last;

    logic       busy, accept, is_cont, complete, append, b_single, incl_b;
    logic       flush_held, new_hold;
    logic [2:0] len;
    logic [1:0] eff_hc;
    logic [2:0] n_units;
    logic [7:0] l0, l1, l2, l3;
    logic [CP_BITS-1:0] full_cp;

    assign busy       = (r_rep_cnt != 2'd0);
    assign o_in_ready = !busy && i_push_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        is_cont    = (i_in_byte[7:6] == CONT_TAG);
        len        = lead_length(i_in_byte);
        complete   = (r_hc != 2'd0) && is_cont && (({1'b0, r_hc} + 3'd1) == r_exp);
        append     = (r_hc != 2'd0) && is_cont && !complete;
        b_single   = ((r_hc == 2'd0) || !is_cont) && ((len == LEN_ONE) || i_in_last);
        new_hold   = ((r_hc == 2'd0) || !is_cont) && (len != LEN_ONE) && !i_in_last;
        incl_b     = b_single || (append && i_in_last);
        flush_held = ((r_hc != 2'd0) && !is_cont) || (append && i_in_last);
        eff_hc     = flush_held ? r_hc : 2'd0;
        n_units    = {1'b0, eff_hc} + {2'b00, incl_b};
        l0 = (eff_hc > 2'd0) ? r_held[0] : i_in_byte;
        l1 = (eff_hc > 2'd1) ? r_held[1] : i_in_byte;
        l2 = (eff_hc > 2'd2) ? r_held[2] : i_in_byte;
        l3 = i_in_byte;
        case (r_exp)
            LEN_TWO:   full_cp = CP_BITS'({r_held[0][4:0], i_in_byte[5:0]});
            LEN_THREE: full_cp = CP_BITS'({r_held[0][3:0], r_held[1][5:0], i_in_byte[5:0]});
            LEN_FOUR:  full_cp = CP_BITS'({r_held[0][2:0], r_held[1][5:0],
                                           r_held[2][5:0], i_in_byte[5:0]});
            default:   full_cp = '0;
        endcase
    end

    always_comb begin
        o_push_valid = 1'b0;
        o_push_unit  = '0;
        if (busy) begin
            o_push_valid           = 1'b1;
            o_push_unit.code_point = CP_BITS'(r_rep[0]);
            o_push_unit.unit_bytes = LEN_ONE;
            o_push_unit.final_unit = r_rep_last && (r_rep_cnt == 2'd1);
        end else if (accept && complete) begin
            o_push_valid           = 1'b1;
            o_push_unit.code_point = full_cp;
            o_push_unit.unit_bytes = r_exp;
            o_push_unit.final_unit = i_in_last;
        end else if (accept && (n_units != 3'd0)) begin
            o_push_valid           = 1'b1;
            o_push_unit.code_point = CP_BITS'(l0);
            o_push_unit.unit_bytes = LEN_ONE;
            o_push_unit.final_unit = i_in_last && (n_units == 3'd1);
        end
    end

    always_comb begin
        n_hc  = r_hc;
        n_exp = r_exp;
        if (accept) begin
            if (new_hold) begin
                n_hc  = 2'd1;
                n_exp = len;
            end else if (append && !i_in_last) begin
                n_hc = r_hc + 2'd1;
            end else begin
                n_hc  = 2'd0;
                n_exp = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc       <= 2'd0;
            r_exp      <= 3'd0;
            r_rep_cnt  <= 2'd0;
            r_rep_last <= 1'b0;
        end else begin
            r_hc  <= n_hc;
            r_exp <= n_exp;
            if (busy) begin
                if (i_push_ready) r_rep_cnt <= r_rep_cnt - 2'd1;
            end else if (accept && !complete && (n_units > 3'd1)) begin
                r_rep_cnt  <= 2'(n_units - 3'd1);
                r_rep_last <= i_in_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (busy) begin
            if (i_push_ready) begin
                r_rep[0] <= r_rep[1];
                r_rep[1] <= r_rep[2];
            end
        end else if (accept) begin
            r_rep[0] <= l1;
            r_rep[1] <= l2;
            r_rep[2] <= l3;
        end
        if (accept) begin
            if (new_hold) r_held[0] <= i_in_byte;
            else if (append && !i_in_last) r_held[r_hc] <= i_in_byte;
        end
    end

endmodule

### rtl/uwm_queue.sv
// short unit queue between the front end and the width stage
// depends on uwm_pkg for the unit type and depth
module uwm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  uwm_pkg::t_unit i_push_unit,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output uwm_pkg::t_unit o_pop_unit
);
    import uwm_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_unit         r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          push, pop;

    assign o_push_ready = (r_cnt != (PW+1)'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_unit   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + PW'(1);
            if (pop)  r_rp <= r_rp + PW'(1);
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_push_unit;
    end

endmodule

### rtl/uwm_back.sv
// back end: classifies display width, keeps the running sum, holds the result register
// depends on uwm_pkg; takes units from uwm_queue
module uwm_back #(
    parameter int SUM_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_pop_valid,
    output logic                         o_pop_ready,
    input  uwm_pkg::t_unit               i_pop_unit,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [uwm_pkg::CP_BITS-1:0]  o_code_point,
    output logic [1:0]                   o_cell_cols,
    output logic [2:0]                   o_unit_bytes,
    output logic [15:0]                  o_running_width,
    output logic                         o_final_unit
);
    import uwm_pkg::*;

    localparam int EW = (SUM_BITS > 16) ? SUM_BITS : 16;

    function automatic logic in_rng(input logic [CP_BITS-1:0] c,
                                    input logic [CP_BITS-1:0] lo,
                                    input logic [CP_BITS-1:0] hi);
        in_rng = (c >= lo) && (c <= hi);
    endfunction

    function automatic logic [1:0] cell_width(input logic [CP_BITS-1:0] c);
        logic zero_w, dbl_w;
        begin
            zero_w = (c < 21'h20) ||
                     in_rng(c, 21'h0300, 21'h036f) || in_rng(c, 21'h1ab0, 21'h1aff) ||
                     in_rng(c, 21'h1dc0, 21'h1dff) || in_rng(c, 21'h20d0, 21'h20ff) ||
                     in_rng(c, 21'hfe00, 21'hfe0f) || in_rng(c, 21'hfe20, 21'hfe2f) ||
                     (c == 21'h200d);
            dbl_w  = in_rng(c, 21'h1100, 21'h115f) || (c == 21'h2329) || (c == 21'h232a) ||
                     in_rng(c, 21'h2e80, 21'ha4cf) || in_rng(c, 21'hac00, 21'hd7a3) ||
                     in_rng(c, 21'hf900, 21'hfaff) || in_rng(c, 21'hfe10, 21'hfe19) ||
                     in_rng(c, 21'hfe30, 21'hfe6f) || in_rng(c, 21'hff00, 21'hff60) ||
                     in_rng(c, 21'hffe0, 21'hffe6) || in_rng(c, 21'h1f000, 21'h1faff) ||
                     in_rng(c, 21'h20000, 21'h3fffd);
            if (zero_w) cell_width = WIDTH_ZERO;
            else if (dbl_w) cell_width = WIDTH_DOUBLE;
            else cell_width = WIDTH_SINGLE;
        end
    endfunction

    logic                r_valid;
    logic [CP_BITS-1:0]  r_cp;
    logic [1:0]          r_w;
    logic [2:0]          r_nb;
    logic [15:0]         r_run;
    logic                r_last;
    logic [SUM_BITS-1:0] r_sum;

    logic                pop;
    logic [1:0]          w;
    logic [SUM_BITS:0]   sum_add;
    logic [SUM_BITS-1:0] n_sum;
    logic [EW-1:0]       sum_ext;
    logic [15:0]         n_run;

    assign o_pop_ready = !r_valid || i_ready;
    assign pop         = i_pop_valid && o_pop_ready;

    always_comb begin
        w       = cell_width(i_pop_unit.code_point);
        sum_add = {1'b0, r_sum} + (SUM_BITS+1)'(w);
        n_sum   = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
        sum_ext = EW'(n_sum);
        n_run   = (sum_ext > EW'(RUN_MAX)) ? RUN_MAX : sum_ext[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum   <= '0;
        end else begin
            if (pop) begin
                r_valid <= 1'b1;
                r_sum   <= i_pop_unit.final_unit ? '0 : n_sum;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cp   <= i_pop_unit.code_point;
            r_w    <= w;
            r_nb   <= i_pop_unit.unit_bytes;
            r_run  <= n_run;
            r_last <= i_pop_unit.final_unit;
        end
    end

    assign o_valid         = r_valid;
    assign o_code_point    = r_cp;
    assign o_cell_cols     = r_w;
    assign o_unit_bytes    = r_nb;
    assign o_running_width = r_run;
    assign o_final_unit    = r_last;

endmodule

### rtl/utf8_display_width_meter_core.sv
// top level of the utf-8 display width meter
// depends on uwm_pkg, uwm_front, uwm_queue and uwm_back
//
// usage:
//   input stream: one text byte per transfer on s_axis_tdata, s_axis_tlast on the
//   final byte of a text. output stream: one transfer per utf-8 unit, m_axis_tlast
//   on the last unit of a text.
//   a well-formed byte is taken every cycle while the unit queue has room; a byte
//   that breaks a sequence or ends a text early replays the held bytes as
//   single-byte units, one per cycle while the queue has room, and the front end
//   takes no new byte until every unit it releases is pushed. the unit that a byte
//   closes is written into the unit queue, then the width stage registers its result.
//   the output register refills in the cycle it is taken, so units leave at one per
//   cycle while m_axis_tready is high. when m_axis_tready is low the result holds,
//   the four-entry unit queue fills and s_axis_tready drops until space returns.
//   reset clears the gathering state, the queue, the running sum and output valid.
//   the running width saturates at 2^SUM_BITS-1 and is shown clipped to 16 bits.
module utf8_display_width_meter_core #(
    parameter int SUM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [20:0] code_point, [22:21] display columns,
                                        // [25:23] unit_bytes, [41:26] running_width,
                                        // [47:42] zero
    output logic        m_axis_tlast    // final_unit
);
    import uwm_pkg::*;

    logic  push_valid, push_ready, pop_valid, pop_ready;
    t_unit push_unit, pop_unit;

    logic [CP_BITS-1:0] code_point;
    logic [1:0]         cell_cols;
    logic [2:0]         unit_bytes;
    logic [15:0]        running_width;

    uwm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_unit  (push_unit)
    );

    uwm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_unit  (push_unit),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_unit   (pop_unit)
    );

    uwm_back #(
        .SUM_BITS (SUM_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pop_valid     (pop_valid),
        .o_pop_ready     (pop_ready),
        .i_pop_unit      (pop_unit),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_code_point    (code_point),
        .o_cell_cols     (cell_cols),
        .o_unit_bytes    (unit_bytes),
        .o_running_width (running_width),
        .o_final_unit    (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, running_width, unit_bytes, cell_cols, code_point};

endmodule
